@@ rtl/websocket_frame_deframer_assert.svh @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_assert.svh
// Assertion macros for the frame deframer; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WSDF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define WSDF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define WSDF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define WSDF_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/wsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] HDR_MIN     = 4'd2;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } wsdf_kind_t;

    typedef struct packed {
        wsdf_kind_t  kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [31:0] mask_key;
        logic [63:0] payload_length;
        logic [7:0]  data_byte;
        logic        frame_end;
    } wsdf_result_t;

    typedef struct packed {
        logic        in_payload;
        logic [3:0]  hdr_cnt;
        logic        fin;
        logic [3:0]  opcode;
        logic        hdr_mask;
        logic [6:0]  len7;
        logic [63:0] len_acc;
        logic [31:0] key_acc;
        logic [63:0] bytes_left;
        logic [31:0] key_latch;
        logic        mask_on;
        logic [1:0]  frame_offset;
    } wsdf_state_t;

endpackage

`default_nettype wire

@@ rtl/wsdf_decode.sv @@
// ----------------------------------------------------------------------------
// wsdf_decode
// One parse step: header field capture, completion check, payload unmasking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsdf_decode import wsdf_pkg::*; (
    input  wsdf_state_t  state_i,
    input  logic [7:0]   rx_byte_i,
    output wsdf_state_t  state_o,
    output logic         emit_o,
    output wsdf_result_t result_o
);

    logic [3:0]  cnt_inc;
    logic        msk_cur;
    logic [6:0]  len7_cur;
    logic [3:0]  lbytes;
    logic [3:0]  need;
    logic [3:0]  ext_idx;
    logic [63:0] len_next;
    logic [31:0] key_next;
    logic [63:0] plen;
    logic [31:0] key;
    logic        complete;
    logic [7:0]  key_byte;
    logic [63:0] left_dec;

    always_comb begin
        cnt_inc  = state_i.hdr_cnt + 4'd1;
        msk_cur  = (state_i.hdr_cnt == 4'd1) ? rx_byte_i[7]   : state_i.hdr_mask;
        len7_cur = (state_i.hdr_cnt == 4'd1) ? rx_byte_i[6:0] : state_i.len7;

        if (len7_cur == LEN_EXT16) begin
            lbytes = EXT16_BYTES;
        end else if (len7_cur == LEN_EXT64) begin
            lbytes = EXT64_BYTES;
        end else begin
            lbytes = 4'd0;
        end
        need = HDR_MIN + lbytes + (msk_cur ? KEY_BYTES : 4'd0);

        // bytes past the first two: length first, then key
        ext_idx  = state_i.hdr_cnt - HDR_MIN;
        len_next = state_i.len_acc;
        key_next = state_i.key_acc;
        if (state_i.hdr_cnt >= HDR_MIN) begin
            if (ext_idx < lbytes) begin
                len_next = {state_i.len_acc[55:0], rx_byte_i};
            end else begin
                key_next = {state_i.key_acc[23:0], rx_byte_i};
            end
        end

        plen     = (lbytes == 4'd0) ? {57'd0, len7_cur} : len_next;
        key      = msk_cur ? key_next : 32'd0;
        complete = (cnt_inc >= HDR_MIN) && (cnt_inc == need);

        unique case (state_i.frame_offset)
            2'd0:    key_byte = state_i.key_latch[31:24];
            2'd1:    key_byte = state_i.key_latch[23:16];
            2'd2:    key_byte = state_i.key_latch[15:8];
            default: key_byte = state_i.key_latch[7:0];
        endcase
        left_dec = (state_i.bytes_left != 64'd0) ? state_i.bytes_left - 64'd1
                                                 : state_i.bytes_left;

        state_o  = state_i;
        emit_o   = 1'b0;
        result_o = '0;

        if (state_i.in_payload) begin
            emit_o              = 1'b1;
            result_o.kind       = KIND_DATA;
            result_o.data_byte  = rx_byte_i ^ (state_i.mask_on ? key_byte : 8'd0);
            result_o.frame_end  = (left_dec == 64'd0);
            state_o.frame_offset = state_i.frame_offset + 2'd1;
            state_o.bytes_left   = left_dec;
            state_o.in_payload   = (left_dec != 64'd0);
        end else begin
            state_o.hdr_cnt = cnt_inc;
            state_o.len_acc = len_next;
            state_o.key_acc = key_next;
            if (state_i.hdr_cnt == 4'd0) begin
                state_o.fin     = rx_byte_i[7];
                state_o.opcode  = rx_byte_i[3:0];
                state_o.len_acc = '0;
                state_o.key_acc = '0;
            end
            if (state_i.hdr_cnt == 4'd1) begin
                state_o.hdr_mask = rx_byte_i[7];
                state_o.len7     = rx_byte_i[6:0];
            end
            if (complete) begin
                emit_o                  = 1'b1;
                result_o.kind           = KIND_HEADER;
                result_o.fin            = state_i.fin;
                result_o.opcode         = state_i.opcode;
                result_o.masked         = msk_cur;
                result_o.mask_key       = key;
                result_o.payload_length = plen;
                result_o.frame_end      = (plen == 64'd0);
                state_o.hdr_cnt         = 4'd0;
                state_o.key_latch       = key;
                state_o.mask_on         = msk_cur;
                state_o.frame_offset    = 2'd0;
                state_o.bytes_left      = plen;
                state_o.in_payload      = (plen != 64'd0);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/wsdf_out_stage.sv @@
// ----------------------------------------------------------------------------
// wsdf_out_stage
// Result register with valid flag; holds an item until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsdf_out_stage import wsdf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load_valid_i,
    input  wsdf_result_t load_data_i,
    output logic         adv_o,
    output logic         m_valid,
    input  logic         m_ready,
    output wsdf_result_t data_o
);

    logic         valid_reg;
    logic         valid_next;
    wsdf_result_t data_reg;
    wsdf_result_t data_next;

    assign adv_o   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign data_o  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (adv_o) begin
            valid_next = load_valid_i;
            data_next  = load_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header decode and payload unmasking.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  s_      | in  | s_valid/s_ready  | s_rx_byte
//  m_      | out | m_valid/m_ready  | m_kind m_fin m_opcode m_masked m_mask_key
//          |     |                  | m_payload_length m_data_byte m_frame_end
//
//  One byte per cycle sustained while m_ready is high. An accepted byte goes
//  through the input register, then the parse step into the result register,
//  before its item shows on m_. Partial header bytes give no item.
//  Synchronous active-low reset clears the parse position, payload state and both valid flags.
//  With m_ready low the result holds; s_ready stays high only while the input
//  register is empty, so at most one more byte is taken before it drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer import wsdf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_fin,
    output logic [3:0]  m_opcode,
    output logic        m_masked,
    output logic [31:0] m_mask_key,
    output logic [63:0] m_payload_length,
    output logic [7:0]  m_data_byte,
    output logic        m_frame_end
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic [7:0]   in_byte_next;
    wsdf_state_t  state_reg;
    wsdf_state_t  state_next;
    wsdf_state_t  step_state;
    logic         step_emit;
    wsdf_result_t step_result;
    wsdf_result_t out_result;
    logic         adv;

    wsdf_decode u_decode (
        .state_i   (state_reg),
        .rx_byte_i (in_byte_reg),
        .state_o   (step_state),
        .emit_o    (step_emit),
        .result_o  (step_result)
    );

    wsdf_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid_i (in_valid_reg && step_emit),
        .load_data_i  (step_result),
        .adv_o        (adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .data_o       (out_result)
    );

    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_rx_byte;
        end
        state_next = state_reg;
        if (in_valid_reg && adv) begin
            state_next = step_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            state_reg.in_payload <= 1'b0;
            state_reg.hdr_cnt    <= 4'd0;
            state_reg.bytes_left <= 64'd0;
            state_reg.key_latch  <= 32'd0;
            state_reg.mask_on    <= 1'b0;
            state_reg.frame_offset <= 2'd0;
        end else begin
            in_valid_reg         <= in_valid_next;
            state_reg.in_payload <= state_next.in_payload;
            state_reg.hdr_cnt    <= state_next.hdr_cnt;
            state_reg.bytes_left <= state_next.bytes_left;
            state_reg.key_latch  <= state_next.key_latch;
            state_reg.mask_on    <= state_next.mask_on;
            state_reg.frame_offset <= state_next.frame_offset;
        end
        in_byte_reg        <= in_byte_next;
        state_reg.fin      <= state_next.fin;
        state_reg.opcode   <= state_next.opcode;
        state_reg.hdr_mask <= state_next.hdr_mask;
        state_reg.len7     <= state_next.len7;
        state_reg.len_acc  <= state_next.len_acc;
        state_reg.key_acc  <= state_next.key_acc;
    end

    assign m_kind           = out_result.kind;
    assign m_fin            = out_result.fin;
    assign m_opcode         = out_result.opcode;
    assign m_masked         = out_result.masked;
    assign m_mask_key       = out_result.mask_key;
    assign m_payload_length = out_result.payload_length;
    assign m_data_byte      = out_result.data_byte;
    assign m_frame_end      = out_result.frame_end;

    // header count is only live between frames
    `WSDF_ASSERT_IMP(a_cnt_idle_in_payload, aclk, aresetn,
        state_reg.in_payload, state_reg.hdr_cnt == 4'd0)
    // a header never runs past fourteen bytes
    `WSDF_ASSERT_IMP(a_cnt_bound, aclk, aresetn,
        !state_reg.in_payload, state_reg.hdr_cnt < 4'd14)
    // empty frame ends on its header item
    `WSDF_ASSERT_IMP(a_empty_frame_end, aclk, aresetn,
        m_valid && (m_kind == KIND_HEADER), m_frame_end == (m_payload_length == 64'd0))
    // a stalled result keeps the parse state frozen
    `WSDF_ASSERT_NXT(a_stall_freeze, aclk, aresetn,
        m_valid && !m_ready && in_valid_reg, state_reg == $past(state_reg))

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WebSocket frame deframer. Byte streams of frames
// (short, 16-bit and 64-bit lengths, masked and unmasked, empty ones)
// go in through the input channel. A built-in model predicts every header and
// payload item, and each received item is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import wsdf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 40;
    localparam int IDLE_PCT     = 27;

    typedef enum {LEN_SHORT, LEN_16, LEN_64} len_form_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_kind;
    logic        m_fin;
    logic [3:0]  m_opcode;
    logic        m_masked;
    logic [31:0] m_mask_key;
    logic [63:0] m_payload_length;
    logic [7:0]  m_data_byte;
    logic        m_frame_end;

    // deframer model state
    logic        pl_active  = 1'b0;
    int          hdr_count  = 0;
    logic [7:0]  hdr_bytes [0:13];
    logic [63:0] pl_left    = '0;
    logic [31:0] key_word   = '0;
    logic        key_on     = 1'b0;
    logic [1:0]  key_phase  = '0;

    wsdf_result_t pending_results[$];

    int cycle_count    = 0;
    int mismatches     = 0;
    int bytes_accepted = 0;
    int hdr_results    = 0;
    int data_results   = 0;
    int tx_idle_pct    = IDLE_PCT;
    int rx_idle_pct    = IDLE_PCT;
    int hold_left      = 0;

    websocket_frame_deframer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fin            (m_fin),
        .m_opcode         (m_opcode),
        .m_masked         (m_masked),
        .m_mask_key       (m_mask_key),
        .m_payload_length (m_payload_length),
        .m_data_byte      (m_data_byte),
        .m_frame_end      (m_frame_end)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver hold-off, counted down in cycles
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // append one predicted item to the expected queue
    function automatic void queue_expected(input wsdf_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Predict the items caused by one accepted byte.
    function automatic void deframe_byte(input logic [7:0] b);
        wsdf_result_t r;
        logic [6:0]   len7;
        logic         msk;
        int           ext;
        int           need;
        logic [63:0]  plen;
        logic [31:0]  key;
        r = '0;
        if (pl_active) begin
            r.kind = KIND_DATA;
            r.data_byte = key_on ? b ^ key_word[8 * (3 - key_phase) +: 8] : b;
            key_phase++;
            if (pl_left != 0) begin
                pl_left--;
            end
            if (pl_left == 0) begin
                r.frame_end = 1'b1;
                pl_active = 1'b0;
            end
            queue_expected(r);
            return;
        end
        hdr_bytes[hdr_count] = b;
        hdr_count++;
        if (hdr_count < HDR_MIN) begin
            return;
        end
        len7 = hdr_bytes[1][6:0];
        msk  = hdr_bytes[1][7];
        if (len7 == LEN_EXT16) begin
            ext = EXT16_BYTES;
        end else if (len7 == LEN_EXT64) begin
            ext = EXT64_BYTES;
        end else begin
            ext = 0;
        end
        need = HDR_MIN + ext + (msk ? KEY_BYTES : 0);
        if (hdr_count < need) begin
            return;
        end
        plen = '0;
        if (ext == 0) begin
            plen = 64'(len7);
        end
        for (int i = 0; i < ext; i++) begin
            plen = {plen[55:0], hdr_bytes[HDR_MIN + i]};
        end
        key = '0;
        if (msk) begin
            for (int i = 0; i < KEY_BYTES; i++) begin
                key = {key[23:0], hdr_bytes[HDR_MIN + ext + i]};
            end
        end
        r.kind           = KIND_HEADER;
        r.fin            = hdr_bytes[0][7];
        r.opcode         = hdr_bytes[0][3:0];
        r.masked         = msk;
        r.mask_key       = key;
        r.payload_length = plen;
        r.frame_end      = (plen == 0);
        hdr_count = 0;
        key_word  = key;
        key_on    = msk;
        key_phase = '0;
        pl_left   = plen;
        pl_active = (plen != 0);
        queue_expected(r);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic check_result();
        wsdf_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("item received with none expected");
            return;
        end
        want = pending_results.pop_front();
        if (want.kind == KIND_HEADER) begin
            hdr_results++;
        end else begin
            data_results++;
        end
        check_field("kind", m_kind, want.kind);
        check_field("fin", m_fin, want.fin);
        check_field("opcode", m_opcode, want.opcode);
        check_field("masked", m_masked, want.masked);
        check_field("mask_key", m_mask_key, want.mask_key);
        check_field("payload_length", m_payload_length, want.payload_length);
        check_field("data_byte", m_data_byte, want.data_byte);
        check_field("frame_end", m_frame_end, want.frame_end);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // valid stays high across back-to-back items; it only drops for a gap
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_accepted++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_frame(input logic [7:0] head, input logic msk,
                              input len_form_t form, input logic [63:0] plen,
                              input logic [31:0] key, input int npay);
        int         ext;
        logic [6:0] len7;
        unique case (form)
            LEN_16: begin
                len7 = LEN_EXT16;
                ext  = EXT16_BYTES;
            end
            LEN_64: begin
                len7 = LEN_EXT64;
                ext  = EXT64_BYTES;
            end
            default: begin
                len7 = plen[6:0];
                ext  = 0;
            end
        endcase
        send_byte(head);
        send_byte({msk, len7});
        for (int i = ext - 1; i >= 0; i--) begin
            send_byte(plen[8 * i +: 8]);
        end
        if (msk) begin
            for (int i = KEY_BYTES - 1; i >= 0; i--) begin
                send_byte(key[8 * i +: 8]);
            end
        end
        for (int i = 0; i < npay; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // mostly short frames; extended lengths kept small, often non-minimal
    task automatic send_random_frame();
        len_form_t   form;
        logic [63:0] plen;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            form = LEN_SHORT;
            pick = $urandom_range(99);
            if (pick < 10) begin
                plen = 0;
            end else if (pick < 75) begin
                plen = $urandom_range(1, 12);
            end else begin
                plen = $urandom_range(13, 125);
            end
        end else if (pick < 85) begin
            form = LEN_16;
            plen = ($urandom_range(99) < 85) ? $urandom_range(0, 40)
                                              : $urandom_range(41, 300);
        end else begin
            form = LEN_64;
            plen = $urandom_range(0, 40);
        end
        send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, plen,
                   $urandom, int'(plen));
    endtask

    task automatic test_directed_headers();
        // empty frames end on the header item, then a one-byte frame with a 16-bit length
        send_frame(8'hFF, 1'b0, LEN_SHORT, 0, '0, 0);
        send_frame(8'h89, 1'b1, LEN_SHORT, 0, 32'hFFFF_FFFF, 0);
        send_frame(8'h00, 1'b0, LEN_16, 1, '0, 1);
    endtask

    task automatic test_masked_payload();
        // five bytes so the key index wraps
        send_frame(8'h81, 1'b1, LEN_SHORT, 5, 32'hA5C3_0F96, 5);
    endtask

    task automatic test_random_traffic(input int nbytes);
        int target;
        target = bytes_accepted + nbytes;
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct <= IDLE_PCT;
        while (bytes_accepted < target) begin
            send_random_frame();
        end
    endtask

    task automatic test_no_idle_stretch(input int nbytes);
        int target;
        target = bytes_accepted + nbytes;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        while (bytes_accepted < target) begin
            send_random_frame();
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct <= IDLE_PCT;
    endtask

    task automatic test_backpressure();
        // receiver stalls long enough for the input side to fill and stop
        hold_left <= 150;
        send_frame(8'h82, 1'b1, LEN_16, 64, $urandom, 64);
        wait_all_results();
    endtask

    task automatic test_raw_length_top_bit();
        // 14-byte header, length taken raw; the frame never ends in this run
        wait_all_results();
        send_frame(8'h82, 1'b1, LEN_64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 8);
    endtask

    initial begin
        for (int i = 0; i < 14; i++) begin
            hdr_bytes[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_headers();
        test_masked_payload();
        test_random_traffic(300);
        test_no_idle_stretch(250);
        test_backpressure();
        test_random_traffic(360);
        test_raw_length_top_bit();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d bytes in, %0d header and %0d payload items checked, %0d mismatches",
                 bytes_accepted, hdr_results, data_results, mismatches);
        $display("frames: empty, masked, 16/64-bit lengths, 14-byte header, long stall");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
